// ===== hdl/abump_pkg.sv =====
// ----------------------------------------------------------------------------
// abump_pkg
// Shared types and codes for the arena bump allocator: request and response
// transaction layouts, function and status codes, sequencer states.
// ----------------------------------------------------------------------------
package abump_pkg;

   // Request transaction
   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] request_size;
      logic [31:0] element_count;
   } req_type;

   // Response transaction
   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  block_index;
      logic [31:0] start_offset;
      logic [31:0] region_length;
      logic        zero_fill;
   } rsp_type;

   // Function codes
   localparam logic [1:0] FUNC_ALLOC  = 2'd0;
   localparam logic [1:0] FUNC_ZALLOC = 2'd1;
   localparam logic [1:0] FUNC_REWIND = 2'd2;
   localparam logic [1:0] FUNC_NONE   = 2'd3;

   // Status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_ZERO     = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;
   localparam logic [1:0] STATUS_NO_ROOM  = 2'd3;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SIZE,
      ST_REM,
      ST_READ,
      ST_CHECK,
      ST_GROW
   } state_type;

endpackage

// ===== hdl/arena_bump_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// arena_bump_allocator_unit
// Bump allocator over a table of growing blocks, held in on-chip memory.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_data and raise start; the transaction is taken at a clock edge
//   with start high and busy low. One response follows on rsp_data, marked
//   by rsp_valid for exactly one cycle; the receiver cannot stall it.
//   Rewind, the unused function code and zero-size requests answer in the
//   cycle after acceptance. An allocation runs through a 32x32 multiplier,
//   a range check, a digit-serial alignment remainder and a block walk that
//   reads each block entry from the table memory, then checks it, since the
//   table read is registered. Appending a block doubles the capacity from
//   the default until the request fits, then writes the new entry. busy
//   stays high until the response is issued; the next transaction may be
//   accepted in the same cycle the response is shown.
//   Reset empties the table and returns to block 0; no clearing pass runs.
// ----------------------------------------------------------------------------
module arena_bump_allocator_unit #(
   parameter int MAX_BLOCKS       = 16,
   parameter int ALIGN_BYTES      = 8,
   parameter int DEFAULT_CAPACITY = 4096,
   parameter int SIZE_BITS        = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  abump_pkg::req_type  req_data,
   output logic                rsp_valid,
   output abump_pkg::rsp_type  rsp_data
);

   localparam int NW   = (SIZE_BITS > 32) ? SIZE_BITS : 32;
   localparam int NW1  = NW + 1;
   localparam int OW   = NW + 1;
   localparam int KW   = $clog2(NW + 1);
   localparam int AW   = (ALIGN_BYTES > 1) ? $clog2(ALIGN_BYTES) : 1;
   localparam int CBW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CNTW = $clog2(MAX_BLOCKS + 1);
   localparam logic [NW:0] HALF_LIMIT = NW1'((64'd1 << (SIZE_BITS - 1)) - 64'd1);

   abump_pkg::state_type state_ff, state_in;
   abump_pkg::req_type   req_ff, req_in;
   abump_pkg::rsp_type   rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [63:0]          prod_ff, prod_in;
   logic [NW-1:0]        n_ff, n_in;
   logic [AW-1:0]        round_ff, round_in;
   logic [NW-1:0]        cap_ff, cap_in;
   logic [KW-1:0]        k_ff, k_in;
   logic [CBW-1:0]       current_ff, current_in;
   logic [CNTW-1:0]      count_ff, count_in;
   logic [MAX_BLOCKS-1:0] zeroed_ff, zeroed_in;

   // Block table: aligned used offset and capacity exponent per block
   logic [OW-1:0]        off_mem [MAX_BLOCKS];
   logic [KW-1:0]        log_mem [MAX_BLOCKS];
   logic [OW-1:0]        rd_off_ff;
   logic [KW-1:0]        rd_log_ff;
   logic                 tbl_we;
   logic                 log_we;
   logic [CBW-1:0]       wr_addr;
   logic [OW-1:0]        wr_off;

   logic                 rem_start;
   logic                 rem_done;
   logic [AW-1:0]        rem_round;

   logic [31:0]          mul_b;
   logic [NW-1:0]        blk_cap;
   logic [OW-1:0]        pad;
   logic                 room;
   logic                 last_blk;
   logic                 zfill;

   abump_align_rem #(
      .VALUE_BITS  (NW),
      .ALIGN_BYTES (ALIGN_BYTES)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .value    (n_in),
      .done     (rem_done),
      .round_up (rem_round)
   );

   // Evaluate the block read last cycle
   assign zfill    = (req_ff.func == abump_pkg::FUNC_ZALLOC);
   assign mul_b    = zfill ? req_ff.element_count : 32'd1;
   assign blk_cap  = NW'(DEFAULT_CAPACITY) << rd_log_ff;
   assign pad      = zeroed_ff[current_ff] ? '0 : rd_off_ff;
   assign room     = (pad <= OW'(blk_cap)) && (OW'(n_ff) <= OW'(blk_cap) - pad);
   assign last_blk = (CNTW'(current_ff) + CNTW'(1)) >= count_ff;

   // Sequence one transaction: next state and register updates
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      prod_in      = prod_ff;
      n_in         = n_ff;
      round_in     = round_ff;
      cap_in       = cap_ff;
      k_in         = k_ff;
      current_in   = current_ff;
      count_in     = count_ff;
      zeroed_in    = zeroed_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      rem_start    = 1'b0;
      tbl_we       = 1'b0;
      log_we       = 1'b0;
      wr_addr      = current_ff;
      wr_off       = pad + OW'(n_ff) + OW'(round_ff);

      unique case (state_ff)
         abump_pkg::ST_IDLE: begin
            if (start) begin
               req_in = req_data;
               unique case (req_data.func)
                  abump_pkg::FUNC_ALLOC: begin
                     if (req_data.request_size == '0) begin
                        rsp_in.status = abump_pkg::STATUS_ZERO;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        state_in = abump_pkg::ST_MUL;
                     end
                  end
                  abump_pkg::FUNC_ZALLOC: begin
                     if (req_data.request_size == '0 || req_data.element_count == '0) begin
                        rsp_in.status = abump_pkg::STATUS_ZERO;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        state_in = abump_pkg::ST_MUL;
                     end
                  end
                  abump_pkg::FUNC_REWIND: begin
                     // Mark every offset as cleared, restart at block 0
                     zeroed_in    = '1;
                     current_in   = '0;
                     rsp_valid_in = 1'b1;
                  end
                  abump_pkg::FUNC_NONE: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         abump_pkg::ST_MUL: begin
            prod_in  = 64'(req_ff.request_size) * 64'(mul_b);
            state_in = abump_pkg::ST_SIZE;
         end

         abump_pkg::ST_SIZE: begin
            if (zfill && ((prod_ff >> SIZE_BITS) != 64'd0)) begin
               rsp_in.status = abump_pkg::STATUS_OVERFLOW;
               rsp_valid_in  = 1'b1;
               state_in      = abump_pkg::ST_IDLE;
            end else begin
               n_in      = NW'(prod_ff);
               rem_start = 1'b1;
               state_in  = abump_pkg::ST_REM;
            end
         end

         abump_pkg::ST_REM: begin
            if (rem_done) begin
               round_in = rem_round;
               if (count_ff == '0) begin
                  cap_in   = NW'(DEFAULT_CAPACITY);
                  k_in     = '0;
                  state_in = abump_pkg::ST_GROW;
               end else begin
                  state_in = abump_pkg::ST_READ;
               end
            end
         end

         abump_pkg::ST_READ: begin
            state_in = abump_pkg::ST_CHECK;
         end

         abump_pkg::ST_CHECK: begin
            priority if (room) begin
               // Commit in place and answer
               tbl_we                = 1'b1;
               zeroed_in[current_ff] = 1'b0;
               rsp_in.status         = abump_pkg::STATUS_OK;
               rsp_in.block_index    = 4'(current_ff);
               rsp_in.start_offset   = 32'(pad);
               rsp_in.region_length  = 32'(n_ff);
               rsp_in.zero_fill      = zfill;
               rsp_valid_in          = 1'b1;
               state_in              = abump_pkg::ST_IDLE;
            end else if (last_blk) begin
               cap_in   = NW'(DEFAULT_CAPACITY);
               k_in     = '0;
               state_in = abump_pkg::ST_GROW;
            end else begin
               current_in = current_ff + CBW'(1);
               state_in   = abump_pkg::ST_READ;
            end
         end

         abump_pkg::ST_GROW: begin
            priority if (cap_ff >= n_ff) begin
               if (count_ff >= CNTW'(MAX_BLOCKS)) begin
                  rsp_in.status = abump_pkg::STATUS_NO_ROOM;
                  rsp_valid_in  = 1'b1;
                  state_in      = abump_pkg::ST_IDLE;
               end else begin
                  // Append a block and place the request at its start
                  tbl_we               = 1'b1;
                  log_we               = 1'b1;
                  wr_addr              = CBW'(count_ff);
                  wr_off               = OW'(n_ff) + OW'(round_ff);
                  zeroed_in[wr_addr]   = 1'b0;
                  current_in           = CBW'(count_ff);
                  count_in             = count_ff + CNTW'(1);
                  rsp_in.status        = abump_pkg::STATUS_OK;
                  rsp_in.block_index   = 4'(count_ff);
                  rsp_in.start_offset  = '0;
                  rsp_in.region_length = 32'(n_ff);
                  rsp_in.zero_fill     = zfill;
                  rsp_valid_in         = 1'b1;
                  state_in             = abump_pkg::ST_IDLE;
               end
            end else if (NW1'(cap_ff) > HALF_LIMIT) begin
               rsp_in.status = abump_pkg::STATUS_NO_ROOM;
               rsp_valid_in  = 1'b1;
               state_in      = abump_pkg::ST_IDLE;
            end else begin
               cap_in = cap_ff << 1;
               k_in   = k_ff + KW'(1);
            end
         end

         default: begin
            state_in = abump_pkg::ST_IDLE;
         end
      endcase
   end

   // Hold state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= abump_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Hold table control and response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         current_ff   <= '0;
         count_ff     <= '0;
         zeroed_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         current_ff   <= current_in;
         count_ff     <= count_in;
         zeroed_ff    <= zeroed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold request payload and working values
   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      prod_ff  <= prod_in;
      n_ff     <= n_in;
      round_ff <= round_in;
      cap_ff   <= cap_in;
      k_ff     <= k_in;
      rsp_ff   <= rsp_in;
   end

   // Table memory: one write port, one registered read at the current block.
   // Writes happen only on the last cycle of a transaction, so a read never
   // overlaps a pending write to the same entry.
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         off_mem[wr_addr] <= wr_off;
      end
      if (log_we) begin
         log_mem[wr_addr] <= k_ff;
      end
      rd_off_ff <= off_mem[current_ff];
      rd_log_ff <= log_mem[current_ff];
   end

   assign busy      = (state_ff != abump_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Results are issued only on the way back to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response issued while busy");

   // Failed transactions carry no placement
   a_err_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != abump_pkg::STATUS_OK |->
         rsp_data.block_index == '0 && rsp_data.start_offset == '0 &&
         rsp_data.region_length == '0 && !rsp_data.zero_fill)
      else $error("error response with placement fields");

   // Block count stays within the table
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(MAX_BLOCKS))
      else $error("block count beyond table depth");

   // Walk position stays on an existing block
   a_cur_valid: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 |-> CNTW'(current_ff) < count_ff)
      else $error("current block outside table");

endmodule

// ===== hdl/abump_align_rem.sv =====
// ----------------------------------------------------------------------------
// abump_align_rem
// Digit-serial remainder of a request length by the alignment, four bits a
// cycle, MSB first. Returns the padding that rounds the length up to the
// next multiple of the alignment.
// ----------------------------------------------------------------------------
module abump_align_rem #(
   parameter int VALUE_BITS  = 32,
   parameter int ALIGN_BYTES = 8,
   localparam int AW = (ALIGN_BYTES > 1) ? $clog2(ALIGN_BYTES) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] value,
   output logic                  done,
   output logic [AW-1:0]         round_up
);

   localparam int DIGIT = 4;
   localparam int RW    = ((VALUE_BITS + DIGIT - 1) / DIGIT) * DIGIT;
   localparam int STEPS = RW / DIGIT;
   localparam int CW    = $clog2(STEPS + 1);
   localparam int TW    = AW + 1;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [RW-1:0] shift_ff, shift_in;
   logic [AW-1:0] rem_ff, rem_in;
   logic [TW-1:0] trial;
   logic [AW-1:0] part;
   logic [TW-1:0] diff;

   // Step the remainder one digit a cycle
   always_comb begin
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      done_in  = 1'b0;
      part     = rem_ff;
      trial    = '0;
      for (int i = 0; i < DIGIT; i++) begin
         trial = {part, shift_ff[RW-1-i]};
         if (trial >= TW'(ALIGN_BYTES)) begin
            trial = trial - TW'(ALIGN_BYTES);
         end
         part = trial[AW-1:0];
      end
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = CW'(STEPS);
         shift_in = RW'(value);
         rem_in   = '0;
      end else if (busy_ff) begin
         rem_in   = part;
         shift_in = shift_ff << DIGIT;
         cnt_in   = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Hold the digit shifter and partial remainder
   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   // Turn the remainder into padding
   assign diff     = TW'(ALIGN_BYTES) - {1'b0, rem_ff};
   assign round_up = (rem_ff == '0) ? '0 : diff[AW-1:0];
   assign done     = done_ff;

endmodule

// ===== tb/sv/arena_bump_allocator_checker.sv =====
// ----------------------------------------------------------------------------
// arena_bump_allocator_checker
// Watches the request and response channels of the arena bump allocator,
// predicts each response from its own copy of the block table and compares
// the responses field by field, oldest expectation first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arena_bump_allocator_checker #(
   parameter int MAX_BLOCKS       = 16,
   parameter int ALIGN_BYTES      = 8,
   parameter int DEFAULT_CAPACITY = 4096,
   parameter int SIZE_BITS        = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  abump_pkg::req_type  req_data,
   input  logic                rsp_valid,
   input  abump_pkg::rsp_type  rsp_data,
   output int                  error_total,
   output int                  awaited_total
);

   import abump_pkg::*;

   localparam logic [63:0] SIZE_LIMIT = (64'd1 << SIZE_BITS) - 64'd1;

   // Shadow copy of the block table
   logic [63:0] block_used      [MAX_BLOCKS];
   logic [5:0]  block_doublings [MAX_BLOCKS];
   int          blocks_in_table;
   int          walk_block;

   rsp_type     awaited_rsp [$];
   int          mismatch_tally;

   // Round an offset up to the next multiple of the alignment
   function automatic logic [63:0] round_up(input logic [63:0] v);
      return ((v + 64'(ALIGN_BYTES - 1)) / 64'(ALIGN_BYTES)) * 64'(ALIGN_BYTES);
   endfunction

   function automatic bit room_in(input int b, input logic [63:0] n);
      logic [63:0] cap;
      logic [63:0] pad;
      cap = 64'(DEFAULT_CAPACITY) << block_doublings[b];
      pad = round_up(block_used[b]);
      return (pad <= cap) && (n <= cap - pad);
   endfunction

   // Append a block that doubles from the default size until n fits
   function automatic bit append_block(input logic [63:0] n);
      logic [63:0] cap;
      int          k;
      cap = 64'(DEFAULT_CAPACITY);
      k   = 0;
      while (cap < n) begin
         if (cap > SIZE_LIMIT / 2) return 1'b0;
         cap = cap << 1;
         k++;
      end
      if (blocks_in_table >= MAX_BLOCKS) return 1'b0;
      block_used[blocks_in_table]      = '0;
      block_doublings[blocks_in_table] = 6'(k);
      walk_block                       = blocks_in_table;
      blocks_in_table++;
      return 1'b1;
   endfunction

   // Walk forward from the current block; append when the walk runs out
   function automatic bit seek_block(input logic [63:0] n);
      if (blocks_in_table == 0) return append_block(n);
      if (walk_block >= blocks_in_table) walk_block = blocks_in_table - 1;
      while (!room_in(walk_block, n)) begin
         if (walk_block + 1 >= blocks_in_table) return append_block(n);
         walk_block++;
      end
      return 1'b1;
   endfunction

   // Work out the grant for one request and advance the shadow table
   function automatic rsp_type predict_grant(input req_type r);
      rsp_type     g;
      logic [63:0] n;
      logic [63:0] pad;
      g = '0;
      n = '0;
      case (r.func)
         FUNC_REWIND: begin
            for (int b = 0; b < blocks_in_table; b++) block_used[b] = '0;
            walk_block = 0;
            return g;
         end
         FUNC_NONE: begin
            return g;
         end
         FUNC_ZALLOC: begin
            if (r.element_count == '0 || r.request_size == '0) begin
               g.status = STATUS_ZERO;
               return g;
            end
            n = 64'(r.element_count) * 64'(r.request_size);
            if (n > SIZE_LIMIT) begin
               g.status = STATUS_OVERFLOW;
               return g;
            end
         end
         default: begin
            if (r.request_size == '0) begin
               g.status = STATUS_ZERO;
               return g;
            end
            n = 64'(r.request_size);
         end
      endcase
      if (!seek_block(n) || !room_in(walk_block, n)) begin
         g.status = STATUS_NO_ROOM;
         return g;
      end
      pad                    = round_up(block_used[walk_block]);
      block_used[walk_block] = pad + n;
      g.status        = STATUS_OK;
      g.block_index   = 4'(walk_block);
      g.start_offset  = pad[31:0];
      g.region_length = n[31:0];
      g.zero_fill     = (r.func == FUNC_ZALLOC);
      return g;
   endfunction

   // Compare one response with its expectation, reporting each bad field
   function automatic int field_mismatches(input rsp_type want, input rsp_type got);
      int bad;
      bad = 0;
      if (got.status !== want.status) begin
         $error("status expected %0d actual %0d", want.status, got.status);
         bad++;
      end
      if (got.block_index !== want.block_index) begin
         $error("block_index expected %0d actual %0d", want.block_index, got.block_index);
         bad++;
      end
      if (got.start_offset !== want.start_offset) begin
         $error("start_offset expected %0h actual %0h", want.start_offset, got.start_offset);
         bad++;
      end
      if (got.region_length !== want.region_length) begin
         $error("region_length expected %0h actual %0h", want.region_length,
                got.region_length);
         bad++;
      end
      if (got.zero_fill !== want.zero_fill) begin
         $error("zero_fill expected %0d actual %0d", want.zero_fill, got.zero_fill);
         bad++;
      end
      return bad;
   endfunction

   // Check responses first, then queue the grant for a newly taken request
   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         awaited_rsp.delete();
         blocks_in_table = 0;
         walk_block      = 0;
         mismatch_tally  = 0;
         error_total    <= 0;
         awaited_total  <= 0;
      end else begin
         if (rsp_valid) begin
            if (awaited_rsp.size() == 0) begin
               $error("response transaction with no request outstanding");
               mismatch_tally++;
            end else begin
               want = awaited_rsp.pop_front();
               if (field_mismatches(want, rsp_data) != 0) mismatch_tally++;
            end
         end
         if (start && !busy) awaited_rsp.push_back(predict_grant(req_data));
         awaited_total <= awaited_rsp.size();
         error_total   <= mismatch_tally;
      end
   end

endmodule

// ===== tb/sv/arena_bump_allocator_unit_test.sv =====
// ----------------------------------------------------------------------------
// arena_bump_allocator_unit_test
// Drives the arena bump allocator with directed corner requests and then
// random allocation bursts closed by rewinds, with random gaps on the
// request side; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arena_bump_allocator_unit_test;

   import abump_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 950;
   localparam int QUIET_TAIL   = 800;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   int error_total;
   int awaited_total;
   int stall_cycles = 0;
   int idle_pct     = 0;
   int alloc_sent   = 0;
   int zalloc_sent  = 0;
   int rewind_sent  = 0;
   int unused_sent  = 0;

   arena_bump_allocator_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   arena_bump_allocator_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data),
      .error_total   (error_total),
      .awaited_total (awaited_total)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abort when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Hold one request until taken, then maybe idle for a burst
   task automatic send_request(input logic [1:0] func, input logic [31:0] req_bytes,
                               input logic [31:0] req_count);
      req_type r;
      r.func          = func;
      r.request_size  = req_bytes;
      r.element_count = req_count;
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      case (func)
         FUNC_ALLOC:  alloc_sent++;
         FUNC_ZALLOC: zalloc_sent++;
         FUNC_REWIND: rewind_sent++;
         default:     unused_sent++;
      endcase
      if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   initial begin : stimulus
      int          random_sent;
      int          seq_len;
      int          flavor;
      int          pick;
      logic [31:0] req_bytes;
      logic [31:0] req_count;

      random_sent = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: error codes first, then growth, walk and rewind
      idle_pct = 30;
      send_request(FUNC_ALLOC,  32'h0000_0000, 32'h0000_1234);
      send_request(FUNC_ZALLOC, 32'h0000_0005, 32'h0000_0000);
      send_request(FUNC_ZALLOC, 32'h0000_0000, 32'h0000_0005);
      send_request(FUNC_ZALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(FUNC_ZALLOC, 32'h0001_0000, 32'h0001_0000);
      send_request(FUNC_ZALLOC, 32'hFFFF_FFFF, 32'h0000_0001);
      send_request(FUNC_NONE,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(FUNC_ALLOC,  32'h0000_0001, 32'h0000_0000);
      send_request(FUNC_ALLOC,  32'h0000_0FFE, 32'h0000_0000);
      send_request(FUNC_ALLOC,  32'h0000_0003, 32'h0000_0000);
      send_request(FUNC_ALLOC,  32'h0000_1388, 32'h0000_0000);
      send_request(FUNC_ALLOC,  32'h8000_0000, 32'h0000_0000);
      send_request(FUNC_ALLOC,  32'h8000_0001, 32'h0000_0000);
      send_request(FUNC_ALLOC,  32'hFFFF_FFFF, 32'h0000_0000);
      send_request(FUNC_ZALLOC, 32'h0000_0007, 32'h0000_0003);
      send_request(FUNC_REWIND, 32'h0000_0000, 32'h0000_0000);
      send_request(FUNC_ALLOC,  32'h0000_0008, 32'h0000_0000);
      send_request(FUNC_ALLOC,  32'h0000_1000, 32'h0000_0000);
      send_request(FUNC_ZALLOC, 32'h0000_0001, 32'h8000_0000);
      send_request(FUNC_REWIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(FUNC_ALLOC,  32'h5555_5555, 32'hAAAA_AAAA);
      send_request(FUNC_ALLOC,  32'h2AAA_AAAA, 32'h5555_5555);

      // Random: bursts of allocations with some noise, mostly closed by a rewind
      while (random_sent < RANDOM_ITEMS) begin
         seq_len = $urandom_range(4, 40);
         flavor  = $urandom_range(0, 2);
         if (random_sent >= QUIET_TAIL) begin
            idle_pct = 0;
         end else begin
            case ($urandom_range(0, 2))
               0:       idle_pct = 0;
               1:       idle_pct = 20;
               default: idle_pct = 60;
            endcase
         end
         repeat (seq_len) begin
            pick      = $urandom_range(0, 99);
            req_count = $urandom;
            case (flavor)
               0:       req_bytes = $urandom_range(1, 256);
               1:       req_bytes = $urandom_range(1, 4096);
               default: req_bytes = $urandom_range(1, 32'd1 << $urandom_range(3, 14));
            endcase
            if (pick < 50) begin
               send_request(FUNC_ALLOC, req_bytes, req_count);
            end else if (pick < 68) begin
               send_request(FUNC_ZALLOC, $urandom_range(1, 256), $urandom_range(1, 32));
            end else if (pick < 73) begin
               // grow: needs one or more doublings
               req_bytes = $urandom_range(4097, 32'd1 << $urandom_range(13, 24));
               send_request(FUNC_ALLOC, req_bytes, req_count);
            end else if (pick < 77) begin
               send_request(FUNC_ALLOC, $urandom, req_count);
            end else if (pick < 82) begin
               // wide factors: overflow or too large, now and then a fit
               send_request(FUNC_ZALLOC, $urandom, $urandom_range(1, 32'd1 << $urandom_range(0, 31)));
            end else if (pick < 86) begin
               // capacity boundaries: powers of two, and one past them
               req_bytes = (32'h8000_0000 >> $urandom_range(0, 19)) + $urandom_range(0, 1);
               send_request(FUNC_ALLOC, req_bytes, req_count);
            end else if (pick < 90) begin
               case ($urandom_range(0, 2))
                  0:       send_request(FUNC_ALLOC, 32'h0, req_count);
                  1:       send_request(FUNC_ZALLOC, 32'h0, req_count);
                  default: send_request(FUNC_ZALLOC, $urandom, 32'h0);
               endcase
            end else if (pick < 93) begin
               send_request(FUNC_NONE, $urandom, req_count);
               random_sent--;
            end else begin
               send_request(FUNC_REWIND, $urandom, req_count);
            end
            random_sent++;
         end
         if ($urandom_range(0, 4) != 0) begin
            send_request(FUNC_REWIND, $urandom, $urandom);
            random_sent++;
         end
      end

      // Drain: wait for every response, then let the block settle
      start <= 1'b0;
      @(posedge clock);
      while (awaited_total != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("summary: %0d allocations, %0d zeroed allocations, %0d rewinds, %0d unused codes",
               alloc_sent, zalloc_sent, rewind_sent, unused_sent);
      if (error_total == 0 && awaited_total == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
